[hw/rtl/i2cbb_pkg.sv]
package i2cbb_pkg;

    // Width of each timing register
    localparam int unsigned CFG_W = 16;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_RISEFALL = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    // Reset values of the timing registers
    localparam logic [CFG_W-1:0] RST_RISEFALL = 16'd100;
    localparam logic [CFG_W-1:0] RST_HOLD     = 16'd500;
    localparam logic [CFG_W-1:0] RST_TIMEOUT  = 16'd2200;

    // Command codes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_STOP  = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BUSY    = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;
    localparam logic [1:0] STAT_NACK    = 2'd3;

    // Bits per byte frame, ACK included
    localparam logic [3:0] FRAME_BITS = 4'd9;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_RAISE,
        PH_ST_HOLD1,
        PH_ST_HOLD2,
        PH_B_SETUP,
        PH_B_RAISE,
        PH_B_HIGH,
        PH_B_LOW,
        PH_SP_A,
        PH_SP_B,
        PH_SP_C
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] risefall;
        logic [CFG_W-1:0] hold;
        logic [CFG_W-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] mode;
        logic [6:0] cmd_address;
        logic       cmd_read;
        logic [7:0] cmd_data;
        logic       cmd_last;
        logic       scl_in;
        logic       sda_in;
    } t_tick;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       cmd_accepted;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [1:0] status;
    } t_result;

endpackage

[hw/rtl/i2cbb_cfg.sv]
module i2cbb_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output i2cbb_pkg::t_cfg     o_cfg
);

    i2cbb_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.risefall <= i2cbb_pkg::RST_RISEFALL;
            r_cfg.hold     <= i2cbb_pkg::RST_HOLD;
            r_cfg.timeout  <= i2cbb_pkg::RST_TIMEOUT;
        end else if (wr_en) begin
            case (reg_idx)
                i2cbb_pkg::REG_RISEFALL: r_cfg.risefall <= pwdata[i2cbb_pkg::CFG_W-1:0];
                i2cbb_pkg::REG_HOLD:     r_cfg.hold     <= pwdata[i2cbb_pkg::CFG_W-1:0];
                i2cbb_pkg::REG_TIMEOUT:  r_cfg.timeout  <= pwdata[i2cbb_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            i2cbb_pkg::REG_RISEFALL: prdata = {16'd0, r_cfg.risefall};
            i2cbb_pkg::REG_HOLD:     prdata = {16'd0, r_cfg.hold};
            i2cbb_pkg::REG_TIMEOUT:  prdata = {16'd0, r_cfg.timeout};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/i2cbb_core.sv]
module i2cbb_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  i2cbb_pkg::t_tick     i_tick,
    input  i2cbb_pkg::t_cfg      i_cfg,
    output i2cbb_pkg::t_result   o_res
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // Load value for a counter: saturates when the register exceeds the counter
    function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [i2cbb_pkg::CFG_W-1:0] v);
        logic [31:0] ext;
        ext = {16'd0, v};
        if ((ext >> COUNT_WIDTH) != 32'd0) begin
            sat_cnt = '1;
        end else begin
            sat_cnt = ext[COUNT_WIDTH-1:0];
        end
    endfunction

    i2cbb_pkg::t_phase      r_phase, n_phase;
    logic [3:0]             r_bit, n_bit;
    logic [8:0]             r_shift, n_shift;
    logic [COUNT_WIDTH-1:0] r_delay, n_delay;
    logic [COUNT_WIDTH-1:0] r_poll, n_poll;
    logic [1:0]             r_status, n_status;
    logic [7:0]             r_rdata, n_rdata;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic                   r_is_read, n_is_read;
    logic                   accepted;
    logic                   done;
    logic [3:0]             bit_inc;

    assign bit_inc = r_bit + 4'd1;

    // State registers, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cbb_pkg::PH_IDLE;
            r_bit     <= '0;
            r_shift   <= '0;
            r_delay   <= '0;
            r_poll    <= '0;
            r_status  <= i2cbb_pkg::STAT_OK;
            r_rdata   <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_is_read <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_delay   <= n_delay;
            r_poll    <= n_poll;
            r_status  <= n_status;
            r_rdata   <= n_rdata;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_is_read <= n_is_read;
        end
    end

    // Next state for one tick
    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_delay   = r_delay;
        n_poll    = r_poll;
        n_status  = r_status;
        n_rdata   = r_rdata;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_is_read = r_is_read;
        accepted  = 1'b0;
        done      = 1'b0;

        if (r_phase == i2cbb_pkg::PH_IDLE) begin
            if (i_tick.cmd_valid) begin
                accepted = 1'b1;
                n_status = i2cbb_pkg::STAT_OK;
                case (i_tick.mode)
                    i2cbb_pkg::MODE_START: begin
                        if (i_tick.scl_in && i_tick.sda_in) begin
                            n_sda   = 1'b0;
                            n_phase = i2cbb_pkg::PH_ST_HOLD1;
                            n_delay = sat_cnt(i_cfg.hold);
                        end else begin
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_poll  = sat_cnt(i_cfg.timeout);
                            n_phase = i2cbb_pkg::PH_ST_RAISE;
                            n_delay = sat_cnt(i_cfg.risefall);
                        end
                        n_shift = {i_tick.cmd_address, i_tick.cmd_read, 1'b1};
                    end
                    i2cbb_pkg::MODE_WRITE: begin
                        n_shift   = {i_tick.cmd_data, 1'b1};
                        n_bit     = '0;
                        n_is_read = 1'b0;
                        n_sda     = i_tick.cmd_data[7];
                        n_phase   = i2cbb_pkg::PH_B_SETUP;
                        n_delay   = sat_cnt(i_cfg.risefall);
                    end
                    i2cbb_pkg::MODE_READ: begin
                        n_shift   = {8'hFF, i_tick.cmd_last};
                        n_bit     = '0;
                        n_is_read = 1'b1;
                        n_sda     = 1'b1;
                        n_phase   = i2cbb_pkg::PH_B_SETUP;
                        n_delay   = sat_cnt(i_cfg.risefall);
                    end
                    default: begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_phase = i2cbb_pkg::PH_SP_A;
                        n_delay = sat_cnt(i_cfg.risefall);
                    end
                endcase
            end
        end else if (r_delay > CNT_ONE) begin
            n_delay = r_delay - CNT_ONE;
        end else begin
            case (r_phase)
                i2cbb_pkg::PH_ST_RAISE, i2cbb_pkg::PH_B_RAISE: begin
                    if (i_tick.scl_in) begin
                        if (r_phase == i2cbb_pkg::PH_ST_RAISE) begin
                            n_sda   = 1'b0;
                            n_phase = i2cbb_pkg::PH_ST_HOLD1;
                        end else begin
                            n_phase = i2cbb_pkg::PH_B_HIGH;
                        end
                        n_delay = sat_cnt(i_cfg.hold);
                    end else if (r_poll <= CNT_ONE) begin
                        // stretch gave out
                        if (r_phase == i2cbb_pkg::PH_ST_RAISE) begin
                            n_status = i2cbb_pkg::STAT_BUSY;
                            n_sda    = 1'b0;
                            n_phase  = i2cbb_pkg::PH_ST_HOLD1;
                            n_delay  = sat_cnt(i_cfg.hold);
                        end else begin
                            n_status = i2cbb_pkg::STAT_TIMEOUT;
                            n_phase  = i2cbb_pkg::PH_IDLE;
                            done     = 1'b1;
                        end
                    end else begin
                        n_poll  = r_poll - CNT_ONE;
                        n_delay = sat_cnt(i_cfg.risefall);
                    end
                end
                i2cbb_pkg::PH_ST_HOLD1: begin
                    n_scl   = 1'b0;
                    n_phase = i2cbb_pkg::PH_ST_HOLD2;
                    n_delay = sat_cnt(i_cfg.hold);
                end
                i2cbb_pkg::PH_ST_HOLD2: begin
                    if (r_status == i2cbb_pkg::STAT_OK) begin
                        // send the address byte
                        n_bit     = '0;
                        n_is_read = 1'b0;
                        n_sda     = r_shift[8];
                        n_phase   = i2cbb_pkg::PH_B_SETUP;
                        n_delay   = sat_cnt(i_cfg.risefall);
                    end else begin
                        n_phase = i2cbb_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                end
                i2cbb_pkg::PH_B_SETUP: begin
                    n_scl   = 1'b1;
                    n_poll  = sat_cnt(i_cfg.timeout);
                    n_phase = i2cbb_pkg::PH_B_RAISE;
                    n_delay = sat_cnt(i_cfg.risefall);
                end
                i2cbb_pkg::PH_B_HIGH: begin
                    n_shift = {r_shift[7:0], i_tick.sda_in};
                    n_scl   = 1'b0;
                    n_phase = i2cbb_pkg::PH_B_LOW;
                    n_delay = sat_cnt(i_cfg.hold);
                end
                i2cbb_pkg::PH_B_LOW: begin
                    n_bit = bit_inc;
                    if (bit_inc >= i2cbb_pkg::FRAME_BITS) begin
                        if (r_is_read) begin
                            n_rdata  = r_shift[8:1];
                            n_status = i2cbb_pkg::STAT_OK;
                        end else begin
                            n_status = r_shift[0] ? i2cbb_pkg::STAT_NACK : i2cbb_pkg::STAT_OK;
                        end
                        n_phase = i2cbb_pkg::PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_sda   = r_shift[8];
                        n_phase = i2cbb_pkg::PH_B_SETUP;
                        n_delay = sat_cnt(i_cfg.risefall);
                    end
                end
                i2cbb_pkg::PH_SP_A: begin
                    n_scl   = 1'b1;
                    n_phase = i2cbb_pkg::PH_SP_B;
                    n_delay = sat_cnt(i_cfg.hold);
                end
                i2cbb_pkg::PH_SP_B: begin
                    n_sda   = 1'b1;
                    n_phase = i2cbb_pkg::PH_SP_C;
                    n_delay = sat_cnt(i_cfg.hold);
                end
                default: begin
                    n_phase = i2cbb_pkg::PH_IDLE;
                    done    = 1'b1;
                end
            endcase
        end
    end

    // Result of this tick, taken from the post-tick state
    always_comb begin
        o_res.scl_drive    = n_scl;
        o_res.sda_drive    = n_sda;
        o_res.cmd_accepted = accepted;
        o_res.busy_res     = (n_phase != i2cbb_pkg::PH_IDLE);
        o_res.done_res     = done;
        o_res.read_data    = n_rdata;
        o_res.status       = n_status;
    end

`ifndef NO_ASSERTIONS
    // A finished command leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> (r_phase == i2cbb_pkg::PH_IDLE))
        else $error("done without returning to idle");

    // Commands are only taken while idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.cmd_accepted) |-> (r_phase == i2cbb_pkg::PH_IDLE))
        else $error("command taken while busy");

    // Bit counter never runs past one frame
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit <= i2cbb_pkg::FRAME_BITS))
        else $error("bit counter out of range");

    // State only moves on a tick
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_status) && $stable(r_phase) && $stable(r_delay)))
        else $error("state changed without a tick");
`endif

endmodule

[hw/rtl/i2c_bit_bang_master.sv]
// Open-drain I2C master stepped one tick per input transaction.
// Input stream: each transaction is one tick carrying sensed SCL/SDA and an
// optional command (tuser bit 0 offers it, tuser[2:1] selects start, write,
// read or stop; tlast asks for NACK on the final read byte).
// Output stream: exactly one transaction per input tick with the line drives
// (1 releases the line), command taken flag, busy, done pulse, the last byte
// read and the status of the last finished command.
// The result is registered: one input register and one result register with
// the step logic between them.
// One tick per cycle unless the output stalls; the step logic is a single pass
// over the sequencer state, and the result register frees once it is taken.
// When the output stalls the result register holds, the input register fills,
// and s_axis_tready drops until the output moves again; no tick is lost.
// Timing (rise/fall wait, hold time, SCL poll limit) comes from APB regs 0x0,
// 0x4, 0x8, to be written only while no command is running; not enforced.
// Reset is synchronous: both lines released, sequencer idle, status ok, read
// data zero, timing registers back to 100, 500 and 2200 ticks.
module i2c_bit_bang_master #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // cmd_address[6:0], cmd_read[7], cmd_data[15:8], scl_in[16], sda_in[17]
    input  logic [23:0] i_s_axis_tdata,
    // cmd_valid[0], mode[2:1]
    input  logic [2:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // scl_drive[0], sda_drive[1], cmd_accepted[2], busy_res[3], done_res[4],
    // read_data[12:5], status[14:13]
    output logic [15:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    i2cbb_pkg::t_cfg    cfg;
    i2cbb_pkg::t_tick   in_tick;
    i2cbb_pkg::t_tick   r_tick;
    i2cbb_pkg::t_result res;
    logic               r_in_valid;
    logic               r_out_valid;
    logic [15:0]        r_out_data;
    logic               step;
    logic               in_fire;

    // Unpack the input transaction
    always_comb begin
        in_tick.cmd_valid   = i_s_axis_tuser[0];
        in_tick.mode        = i_s_axis_tuser[2:1];
        in_tick.cmd_address = i_s_axis_tdata[6:0];
        in_tick.cmd_read    = i_s_axis_tdata[7];
        in_tick.cmd_data    = i_s_axis_tdata[15:8];
        in_tick.cmd_last    = i_s_axis_tlast;
        in_tick.scl_in      = i_s_axis_tdata[16];
        in_tick.sda_in      = i_s_axis_tdata[17];
    end

    // Step when a tick is held and the result slot is free or draining
    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tick <= in_tick;
        end
    end

    i2cbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    i2cbb_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_tick  (r_tick),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {1'b0, res.status, res.read_data, res.done_res, res.busy_res,
                           res.cmd_accepted, res.sda_drive, res.scl_drive};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
